[hw/rtl/maximal_square_area_top_assert.svh]
// Assertion macros for the maximal square area block.
// Included by the top level; expects signals clk and arst_n in scope.
`ifndef MAXIMAL_SQUARE_AREA_TOP_ASSERT_SVH
`define MAXIMAL_SQUARE_AREA_TOP_ASSERT_SVH

// Checked on every rising edge outside of reset.
`define MSA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define MSA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/msa_pkg.sv]
// Shared types and constants of the maximal square area block.
// No dependencies; imported by the top level, msa_cell_calc, the checker and the testbench.
package msa_pkg;

	localparam int ROW_W        = 11;
	localparam int AREA_W       = 21;
	localparam int MAX_COLS_DEF = 1024;
	localparam int APB_ADDR_W   = 3;

	localparam logic [ROW_W-1:0] ROW_WIDTH_RST = ROW_W'(1024);
	localparam logic             REG_ROW_WIDTH = 1'b0;

	typedef struct packed {
		logic is_one;
		logic last;
		logic first_row;
		logic col_zero;
	} msa_item_t;

endpackage

[hw/rtl/msa_line_store.sv]
// Line store holding the square sides of the previous matrix row.
// Single write port and one registered read port; no dependencies.
module msa_line_store #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10,
	parameter int DATA_W = 11
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hw/rtl/msa_cell_calc.sv]
// Per-cell side computation with the left, up-left and best side registers.
// Depends on msa_pkg for the cell item struct.
module msa_cell_calc import msa_pkg::*; #(
	parameter int SIDE_W = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  msa_item_t         item,
	input  logic [SIDE_W-1:0] up_mem,
	input  logic              bypass,
	input  logic [SIDE_W-1:0] bypass_side,
	output logic [SIDE_W-1:0] side,
	output logic [SIDE_W-1:0] best_next
);

	logic [SIDE_W-1:0] left_q;
	logic [SIDE_W-1:0] diag_q;
	logic [SIDE_W-1:0] best_q;
	logic [SIDE_W-1:0] up;
	logic [SIDE_W-1:0] left;
	logic [SIDE_W-1:0] diag;
	logic [SIDE_W-1:0] min_ul;
	logic [SIDE_W-1:0] min_all;

	always_comb begin
		up      = item.first_row ? '0 : (bypass ? bypass_side : up_mem);
		left    = item.col_zero ? '0 : left_q;
		diag    = (item.first_row || item.col_zero) ? '0 : diag_q;
		min_ul  = (up < left) ? up : left;
		min_all = (min_ul < diag) ? min_ul : diag;
		side    = item.is_one ? min_all + SIDE_W'(1) : '0;
		best_next = (side > best_q) ? side : best_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			diag_q <= '0;
			best_q <= '0;
		end else if (advance) begin
			if (item.last) begin
				left_q <= '0;
				diag_q <= '0;
				best_q <= '0;
			end else begin
				left_q <= side;
				diag_q <= up;
				best_q <= best_next;
			end
		end
	end

endmodule

[hw/rtl/maximal_square_area_top.sv]
// Maximal square area block: one cell transaction per clock unless
// stalled, one area transaction per matrix. Depends on msa_pkg,
// msa_line_store, msa_cell_calc. Cells of a binary matrix enter in
// row-major order, one per clock unless stalled, with the row width taken
// from the row_width register (0 or above MAX_COLS means MAX_COLS). The area
// of the largest all-ones square is registered at the output once the cell
// marked last, accepted into the s1 stage, advances out of it. The line
// store is read at acceptance, ahead of the side computation in s1; the
// next cell can be accepted in the following clock. The line store needs no
// clearing pass after reset. Input stall rises only while an area
// transaction waits and the last cell of the following matrix is ready.
`include "maximal_square_area_top_assert.svh"

module maximal_square_area_top import msa_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cell_req,
	input  logic                  last_cell,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [AREA_W-1:0]     area
);

	localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int SIDE_W = $clog2(MAX_COLS + 1);
	localparam int MAXC_W = $clog2(MAX_COLS + 1);
	localparam int CMP_W  = (MAXC_W > ROW_W) ? MAXC_W + 1 : ROW_W + 1;
	localparam int PROD_W = 2 * SIDE_W;

	logic [ROW_W-1:0]  row_width_q;
	logic [COL_W-1:0]  col_q;
	logic              first_row_q;
	logic [CMP_W-1:0]  act_width;
	logic              row_end;
	logic              in_accept;
	logic              cfg_write;

	logic              valid_s1;
	msa_item_t         item_s1;
	logic [COL_W-1:0]  col_s1;
	logic              bypass_s1;
	logic [SIDE_W-1:0] bypass_side_s1;
	logic              hold_s1;
	logic              adv_s1;

	logic [SIDE_W-1:0] up_mem;
	logic [SIDE_W-1:0] side;
	logic [SIDE_W-1:0] best_next;
	logic [PROD_W-1:0] square;

	logic              out_valid_q;
	logic [AREA_W-1:0] area_q;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_ROW_WIDTH) ? 32'(row_width_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_RST;
		end else if (cfg_write && paddr[2] == REG_ROW_WIDTH) begin
			row_width_q <= pwdata[ROW_W-1:0];
		end
	end

	always_comb begin
		if (row_width_q == '0 || CMP_W'(row_width_q) > CMP_W'(MAX_COLS)) begin
			act_width = CMP_W'(MAX_COLS);
		end else begin
			act_width = CMP_W'(row_width_q);
		end
		row_end = (CMP_W'(col_q) + CMP_W'(1)) >= act_width;
	end

	assign hold_s1   = item_s1.last && out_valid_q && out_stall;
	assign adv_s1    = valid_s1 && !hold_s1;
	assign in_stall  = valid_s1 && hold_s1;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			first_row_q <= 1'b1;
			valid_s1    <= 1'b0;
		end else begin
			if (in_accept) begin
				if (last_cell) begin
					col_q       <= '0;
					first_row_q <= 1'b1;
				end else if (row_end) begin
					col_q       <= '0;
					first_row_q <= 1'b0;
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.is_one    <= cell_req;
			item_s1.last      <= last_cell;
			item_s1.first_row <= first_row_q;
			item_s1.col_zero  <= (col_q == '0);
			col_s1            <= col_q;
			bypass_s1         <= adv_s1 && (col_s1 == col_q);
			bypass_side_s1    <= side;
		end
	end

	msa_line_store #(
		.DEPTH  (MAX_COLS),
		.ADDR_W (COL_W),
		.DATA_W (SIDE_W)
	) u_line_store (
		.clk     (clk),
		.wr_en   (adv_s1),
		.wr_addr (col_s1),
		.wr_data (side),
		.rd_en   (in_accept),
		.rd_addr (col_q),
		.rd_data (up_mem)
	);

	msa_cell_calc #(
		.SIDE_W (SIDE_W)
	) u_cell_calc (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (adv_s1),
		.item        (item_s1),
		.up_mem      (up_mem),
		.bypass      (bypass_s1),
		.bypass_side (bypass_side_s1),
		.side        (side),
		.best_next   (best_next)
	);

	assign square = PROD_W'(best_next) * PROD_W'(best_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && item_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_s1.last) begin
			area_q <= AREA_W'(square);
		end
	end

	assign out_valid = out_valid_q;
	assign area      = area_q;

	`MSA_ASSERT(a_last_delivers, adv_s1 && item_s1.last |=> out_valid, "last cell gave no area")
	`MSA_ASSERT(a_stall_cause, in_stall |-> valid_s1 && item_s1.last && out_valid_q, "stall without a waiting area")
	`MSA_ASSERT(a_last_clears, in_accept && last_cell |=> col_q == '0 && first_row_q, "matrix state not cleared")
	`MSA_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid && !in_stall, "activity during reset")

endmodule

[dv/maximal_square_area_checker.sv]
`timescale 1ns / 100ps
// Checker for the maximal square area block: follows register writes and reads,
// predicts the area of every matrix and compares each area transaction.
// Depends on msa_pkg; instantiated beside the block by maximal_square_area_top_tb.
module maximal_square_area_checker import msa_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	input  logic [31:0]           prdata,
	input  logic                  pready,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic                  cell_req,
	input  logic                  last_cell,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [AREA_W-1:0]     area,
	output int                    errors,
	output int                    pending
);
	localparam logic [APB_ADDR_W-1:0] ROW_WIDTH_ADDR = APB_ADDR_W'({REG_ROW_WIDTH, 2'b00});

	logic [ROW_W-1:0]  width_q;
	logic [ROW_W-1:0]  upper_sides [MAX_COLS];
	int unsigned       left_side;
	int unsigned       diag_side;
	int unsigned       col_idx;
	int unsigned       best_side;
	bit                first_row;
	logic [AREA_W-1:0] areas_due [$];
	int                err_count;

	int unsigned       span;
	int unsigned       col;
	int unsigned       up;
	int unsigned       lf;
	int unsigned       dg;
	int unsigned       side;
	int unsigned       low;
	logic [AREA_W-1:0] due;

	task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
		if (err_count < 10)
			$display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
		err_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q = ROW_WIDTH_RST;
			foreach (upper_sides[i])
				upper_sides[i] = '0;
			left_side = 0;
			diag_side = 0;
			col_idx = 0;
			best_side = 0;
			first_row = 1'b1;
			areas_due.delete();
			err_count = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pready && paddr == ROW_WIDTH_ADDR) begin
				if (pwrite)
					width_q = pwdata[ROW_W-1:0];
				else if (prdata[ROW_W-1:0] !== width_q)
					report("row_width readback", width_q, prdata[ROW_W-1:0]);
			end

			if (in_valid && !in_stall) begin
				span = (width_q == 0 || width_q > MAX_COLS) ? MAX_COLS : width_q;
				col = col_idx % MAX_COLS;
				up = first_row ? 0 : upper_sides[col];
				lf = (col == 0) ? 0 : left_side;
				dg = (first_row || col == 0) ? 0 : diag_side;
				low = (up < lf) ? up : lf;
				low = (low < dg) ? low : dg;
				side = cell_req ? low + 1 : 0;
				upper_sides[col] = ROW_W'(side);
				diag_side = up;
				left_side = side;
				if (side > best_side)
					best_side = side;
				if (col + 1 >= span) begin
					col_idx = 0;
					first_row = 1'b0;
				end else begin
					col_idx = col + 1;
				end
				if (last_cell) begin
					areas_due.push_back(AREA_W'(best_side * best_side));
					left_side = 0;
					diag_side = 0;
					col_idx = 0;
					best_side = 0;
					first_row = 1'b1;
				end
			end

			if (out_valid && !out_stall) begin
				if (areas_due.size() == 0) begin
					report("unexpected area transaction", 'x, area);
				end else begin
					due = areas_due.pop_front();
					if (area !== due)
						report("area", due, area);
				end
			end

			errors <= err_count;
			pending <= areas_due.size();
		end
	end

endmodule

[dv/maximal_square_area_top_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the maximal square area block: clock, reset, register
// writes and cell transactions, with the checker instantiated beside the block.
// Depends on msa_pkg, maximal_square_area_top and maximal_square_area_checker.
module maximal_square_area_top_tb;
	import msa_pkg::*;

	localparam logic [APB_ADDR_W-1:0] ROW_WIDTH_ADDR = APB_ADDR_W'({REG_ROW_WIDTH, 2'b00});
	localparam int RANDOM_ITEMS = 180;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  in_valid;
	logic                  in_stall;
	logic                  cell_req;
	logic                  last_cell;
	logic                  out_valid;
	logic                  out_stall;
	logic [AREA_W-1:0]     area;

	int errors;
	int pending;
	int cycles;
	int cur_width;
	int random_items;
	int n_cells;
	int shrink_at;
	bit quiet;
	bit calm;
	bit hold_req;
	bit hold_done;
	bit big_done;

	maximal_square_area_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cell_req  (cell_req),
		.last_cell (last_cell),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.area      (area)
	);

	maximal_square_area_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cell_req  (cell_req),
		.last_cell (last_cell),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.area      (area),
		.errors    (errors),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_cell(input logic cell_val, input logic last);
		if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cell_req <= cell_val;
		last_cell <= last;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [ROW_W-1:0] value);
		logic [31:0] word;
		word = $urandom();
		word[ROW_W-1:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ROW_WIDTH_ADDR;
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (wr)
			cur_width = (value == 0 || value > MAX_COLS_DEF) ? MAX_COLS_DEF : value;
	endtask

	task automatic send_matrix(input int n, input int pct, input int shrink_point);
		for (int i = 0; i < n; i++) begin
			if (i == shrink_point) begin
				settle();
				apb_access(1'b1, ROW_W'($urandom_range(1, cur_width)));
			end
			send_cell($urandom_range(0, 99) < pct, i == n - 1);
		end
	endtask

	function automatic logic [ROW_W-1:0] pick_width();
		int r;
		r = $urandom_range(0, 19);
		case (r)
			0: return '0;
			1: return ROW_W'(2047);
			2: return ROW_W'(MAX_COLS_DEF);
			3: return ROW_W'($urandom_range(MAX_COLS_DEF + 1, 2046));
			4: return ROW_W'($urandom_range(17, 200));
			default: return ROW_W'($urandom_range(1, 16));
		endcase
	endfunction

	function automatic int pick_density();
		int r;
		r = $urandom_range(0, 3);
		case (r)
			0: return 50;
			1: return 85;
			2: return 97;
			default: return 100;
		endcase
	endfunction

	initial begin
		int sz;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		cell_req = 1'b0;
		last_cell = 1'b0;
		out_stall = 1'b0;
		cur_width = MAX_COLS_DEF;
		#1 arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed: single cells at the reset width, a one-column matrix, a full
		// 2x2 square, a zero cell under three ones, a width shrunk mid-row, and
		// an oversized width.
		send_matrix(1, 100, -1);
		send_matrix(1, 0, -1);
		settle();
		apb_access(1'b1, ROW_W'(1));
		apb_access(1'b0, '0);
		send_matrix(4, 100, -1);
		settle();
		apb_access(1'b1, ROW_W'(2));
		send_matrix(4, 100, -1);
		send_cell(1'b1, 1'b0);
		send_cell(1'b1, 1'b0);
		send_cell(1'b1, 1'b0);
		send_cell(1'b0, 1'b1);
		settle();
		apb_access(1'b1, ROW_W'(3));
		send_cell(1'b1, 1'b0);
		send_cell(1'b1, 1'b0);
		settle();
		apb_access(1'b1, ROW_W'(1));
		send_cell(1'b1, 1'b0);
		send_cell(1'b1, 1'b1);
		settle();
		apb_access(1'b1, ROW_W'(2047));
		apb_access(1'b0, '0);
		send_cell(1'b1, 1'b0);
		send_cell(1'b0, 1'b1);

		while (random_items < RANDOM_ITEMS) begin
			if (random_items > 150)
				quiet = 1'b1;

			if (!big_done && random_items > 30) begin
				settle();
				apb_access(1'b1, '0);
				send_matrix(MAX_COLS_DEF + 8, 97, -1);
				big_done = 1'b1;
			end

			if (!hold_req && random_items > 80) begin
				hold_req = 1'b1;
				while (!out_stall) @(posedge clk);
				calm = 1'b1;
				repeat (40) begin
					send_matrix(1, 50, -1);
					random_items++;
				end
				calm = 1'b0;
				in_valid <= 1'b0;
				do @(posedge clk); while (!hold_done);
			end

			if ($urandom_range(0, 2) == 0) begin
				settle();
				apb_access(1'b1, pick_width());
				if ($urandom_range(0, 3) == 0)
					apb_access(1'b0, '0);
			end

			if (cur_width <= 16) begin
				sz = cur_width * $urandom_range(1, 6);
				n_cells = $urandom_range(1, (sz < 48) ? sz : 48);
			end else begin
				n_cells = $urandom_range(1, 40);
			end
			shrink_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_cells - 1) : -1;
			send_matrix(n_cells, pick_density(), shrink_at);
			random_items += n_cells;
		end

		quiet = 1'b1;
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
		end
	end

endmodule
